/* rtl/bmci_pkg.sv */
package bmci_pkg;

    localparam int MAX_ROWS = 1024;
    localparam int ROW_AW   = $clog2(MAX_ROWS);
    localparam int CNT_W    = ROW_AW + 1;
    localparam int ROW_W    = 26;

    localparam logic CFG_ROW_OFFSET = 1'b0;
    localparam logic CFG_GUIDE_ROWS = 1'b1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic signed [24:0] center;
        logic [15:0]        pre;
        logic [15:0]        after;
        logic [31:0]        base;
    } t_row_entry;

    typedef struct packed {
        logic        valid;
        logic        lookup;
        logic        hit;
        logic [31:0] index;
        logic [31:0] total;
        logic [23:0] col;
    } t_req;

endpackage

/* rtl/bmci_row_ram.sv */
module bmci_row_ram import bmci_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ROW_AW-1:0] i_waddr,
    input  t_row_entry        i_wdata,
    input  logic              i_re,
    input  logic [ROW_AW-1:0] i_raddr,
    output t_row_entry        o_rdata
);

    t_row_entry r_mem [MAX_ROWS];
    t_row_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bmci_band_calc.sv */
module bmci_band_calc import bmci_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_req        i_req,
    input  t_row_entry  i_row,
    output logic        o_valid,
    output logic        o_hit,
    output logic [31:0] o_buffer_index,
    output logic [31:0] o_total_cells
);

    typedef struct packed {
        logic             valid;
        logic             lookup;
        logic             hit;
        logic [31:0]      index;
        logic [31:0]      total;
        logic             right;
        logic             inband;
        logic [ROW_W-1:0] span;
    } t_s2;

    t_s2               r_s2;
    t_s2               n_s2;
    logic [ROW_W-1:0]  w_col;
    logic [ROW_W-1:0]  w_ctr;
    logic [ROW_W-1:0]  w_diff_r;
    logic [ROW_W-1:0]  w_diff_l;
    logic              r_valid;
    logic              r_hit;
    logic [31:0]       r_index;
    logic [31:0]       r_total;
    logic [31:0]       n_index;
    logic              n_hit;

    // distance from band centre and band check
    always_comb begin
        w_col    = {2'b00, i_req.col};
        w_ctr    = {i_row.center[24], i_row.center};
        w_diff_r = w_col - w_ctr;
        w_diff_l = w_ctr - w_col;
        n_s2        = '0;
        n_s2.valid  = i_req.valid;
        n_s2.lookup = i_req.lookup;
        n_s2.hit    = i_req.hit;
        n_s2.index  = i_req.lookup ? i_row.base : i_req.index;
        n_s2.total  = i_req.total;
        n_s2.right  = !w_diff_r[ROW_W-1] && (w_diff_r != '0);
        n_s2.span   = n_s2.right ? w_diff_r : w_diff_l;
        if (n_s2.right) begin
            n_s2.inband = n_s2.span <= {10'b0, i_row.after};
        end else begin
            n_s2.inband = n_s2.span <= {10'b0, i_row.pre};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2 <= n_s2;
        end
    end

    always_comb begin
        n_hit   = r_s2.hit;
        n_index = r_s2.index;
        if (r_s2.lookup) begin
            n_hit = r_s2.inband;
            if (!r_s2.inband) begin
                n_index = '0;
            end else if (r_s2.right) begin
                n_index = r_s2.index + 32'(r_s2.span);
            end else begin
                n_index = r_s2.index - 32'(r_s2.span);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_s2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit   <= n_hit;
        r_index <= n_index;
        r_total <= r_s2.total;
    end

    assign o_valid        = r_valid;
    assign o_hit          = r_hit;
    assign o_buffer_index = r_index;
    assign o_total_cells  = r_total;

endmodule

/* rtl/banded_matrix_cell_index_unit.sv */
// Banded matrix cell index unit. Every request gives exactly one result, on o_valid,
// after passing the registers r_s1, r_s2 and the output registers; a request may be issued
// in every cycle while busy is low, so one request per cycle is sustained. The row table
// is one synchronous memory: a load writes its row at the accepting edge and a query
// reads its row at the same point, so a query may directly follow the load of the row it
// asks for. busy is high only while reset is applied and in the first cycle after it;
// results cannot be held off, so the receiver must take o_valid whenever it rises. Configuration
// must be written only while no request is in flight; the block itself does not enforce it.
module banded_matrix_cell_index_unit import bmci_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_command,
    input  logic signed [24:0] i_center_col,
    input  logic [15:0]        i_band_before,
    input  logic [15:0]        i_band_after,
    input  logic [23:0]        i_query_row,
    input  logic [23:0]        i_query_col,
    input  logic               i_prior_valid,
    input  logic [31:0]        i_prior_index,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [23:0]        i_cfg_data,
    output logic               o_valid,
    output logic               o_hit,
    output logic [31:0]        o_buffer_index,
    output logic [31:0]        o_total_cells
);

    logic              r_ready;
    logic [23:0]       r_row_offset;
    logic [10:0]       r_guide_rows;
    logic [CNT_W-1:0]  r_rows_loaded;
    logic [31:0]       r_cell_total;
    logic [31:0]       n_cell_total;
    t_req              r_s1;
    t_req              n_s1;
    logic              w_go;
    logic              w_full;
    logic              w_load;
    logic              w_query;
    logic [31:0]       w_base;
    logic [ROW_W-1:0]  w_row;
    logic              w_in_range;
    t_row_entry        w_wdata;
    t_row_entry        w_rdata;

    assign busy    = !r_ready;
    assign w_go    = start && r_ready;
    assign w_full  = r_rows_loaded == CNT_W'(MAX_ROWS);
    assign w_load  = w_go && (i_command == CMD_LOAD) && !w_full;
    assign w_query = w_go && (i_command == CMD_QUERY) && !i_prior_valid;

    assign w_base       = 32'(i_band_before) + r_cell_total;
    assign n_cell_total = r_cell_total + 32'(i_band_before) + 32'(i_band_after) + 32'd1;

    assign w_row      = {2'b00, i_query_row} + ROW_W'(1) - {2'b00, r_row_offset};
    assign w_in_range = !w_row[ROW_W-1]
                        && (w_row < {15'b0, r_guide_rows})
                        && (w_row < ROW_W'(MAX_ROWS));

    always_comb begin
        w_wdata.center = i_center_col;
        w_wdata.pre    = i_band_before;
        w_wdata.after  = i_band_after;
        w_wdata.base   = w_base;
    end

    bmci_row_ram u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (r_rows_loaded[ROW_AW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_query),
        .i_raddr (w_row[ROW_AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready       <= 1'b0;
            r_row_offset  <= '0;
            r_guide_rows  <= '0;
            r_rows_loaded <= '0;
            r_cell_total  <= '0;
        end else begin
            r_ready <= 1'b1;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROW_OFFSET: r_row_offset <= i_cfg_data;
                    CFG_GUIDE_ROWS: r_guide_rows <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (w_load) begin
                r_rows_loaded <= r_rows_loaded + CNT_W'(1);
                r_cell_total  <= n_cell_total;
            end
        end
    end

    always_comb begin
        n_s1        = '0;
        n_s1.valid  = w_go;
        n_s1.col    = i_query_col;
        n_s1.total  = r_cell_total;
        if (i_command == CMD_LOAD) begin
            if (!w_full) begin
                n_s1.index = w_base;
                n_s1.total = n_cell_total;
            end
        end else if (i_prior_valid) begin
            n_s1.hit   = 1'b1;
            n_s1.index = i_prior_index + 32'd1;
        end else begin
            n_s1.lookup = w_in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    bmci_band_calc u_band_calc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (r_s1),
        .i_row          (w_rdata),
        .o_valid        (o_valid),
        .o_hit          (o_hit),
        .o_buffer_index (o_buffer_index),
        .o_total_cells  (o_total_cells)
    );

`ifndef SYNTHESIS
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == $past(w_go, 3))
        else $error("result strobe does not follow request by three cycles");

    a_rows_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows_loaded <= CNT_W'(MAX_ROWS))
        else $error("row count beyond table depth");

    a_full_load_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && (i_command == CMD_LOAD) && w_full)
        |=> ($stable(r_rows_loaded) && $stable(r_cell_total)))
        else $error("load into full table changed state");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit && $past(r_s1.lookup, 2)) |-> (o_buffer_index == 32'd0))
        else $error("missed query returned non-zero index");
`endif

endmodule

/* dv/banded_matrix_cell_index_unit_test.sv */
`timescale 1ns / 1ps

module banded_matrix_cell_index_unit_test import bmci_pkg::*; ();

    localparam int   RAND_ITEMS  = 1800;
    localparam int   CYCLE_LIMIT = 400000;
    localparam int   COORD_MAX   = 24'hFFFFFF;

    typedef struct {
        logic               command;
        logic signed [24:0] center;
        logic [15:0]        left_cells;
        logic [15:0]        right_cells;
        logic [23:0]        qrow;
        logic [23:0]        qcol;
        logic               pvalid;
        logic [31:0]        pindex;
    } t_cell_req;

    typedef struct {
        logic        hit;
        logic [31:0] index;
        logic [31:0] total;
    } t_cell_result;

    class cell_index_scoreboard;
        logic signed [24:0] center_tab [MAX_ROWS];
        logic [15:0]        left_tab [MAX_ROWS];
        logic [15:0]        right_tab [MAX_ROWS];
        logic [31:0]        base_tab [MAX_ROWS];
        int                 rows_loaded;
        logic [31:0]        cell_total;
        logic [23:0]        row_offset;
        logic [10:0]        guide_rows;
        t_cell_result       expected_q [$];
        int                 errors;
        int                 n_loads;
        int                 n_queries;
        int                 n_hits;
        int                 n_checked;

        function new();
            rows_loaded = 0;
            cell_total  = '0;
            row_offset  = '0;
            guide_rows  = '0;
            errors      = 0;
            n_loads     = 0;
            n_queries   = 0;
            n_hits      = 0;
            n_checked   = 0;
        endfunction

        function void set_reg(logic idx, logic [23:0] data);
            if (idx == CFG_ROW_OFFSET) begin
                row_offset = data;
            end else begin
                guide_rows = data[10:0];
            end
        endfunction

        function void note_request(t_cell_req req);
            t_cell_result res;
            longint       row;
            longint       col;
            longint       ctr;
            longint       span;
            int           r;
            res.hit   = 1'b0;
            res.index = '0;
            if (req.command == CMD_LOAD) begin
                n_loads++;
                // a full guide table ignores the load
                if (rows_loaded < MAX_ROWS) begin
                    res.index              = 32'(req.left_cells) + cell_total;
                    center_tab[rows_loaded] = req.center;
                    left_tab[rows_loaded]   = req.left_cells;
                    right_tab[rows_loaded]  = req.right_cells;
                    base_tab[rows_loaded]   = res.index;
                    rows_loaded++;
                    cell_total = cell_total + 32'(req.left_cells) + 32'(req.right_cells) + 32'd1;
                end
            end else begin
                n_queries++;
                if (req.pvalid) begin
                    res.hit   = 1'b1;
                    res.index = req.pindex + 32'd1;
                end else begin
                    row = longint'(req.qrow) + 1 - longint'(row_offset);
                    if (row >= 0 && row < longint'(guide_rows) && row < MAX_ROWS) begin
                        r   = int'(row);
                        col = longint'(req.qcol);
                        ctr = longint'(center_tab[r]);
                        if (col <= ctr) begin
                            span = ctr - col;
                            if (span <= longint'(left_tab[r])) begin
                                res.hit   = 1'b1;
                                res.index = base_tab[r] - 32'(span);
                            end
                        end else begin
                            span = col - ctr;
                            if (span <= longint'(right_tab[r])) begin
                                res.hit   = 1'b1;
                                res.index = base_tab[r] + 32'(span);
                            end
                        end
                    end
                end
            end
            res.total = cell_total;
            if (res.hit) begin
                n_hits++;
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(logic hit, logic [31:0] index, logic [31:0] total);
            t_cell_result exp_res;
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding: hit %0d index %h total %h",
                       hit, index, total);
                errors++;
            end else begin
                exp_res = expected_q.pop_front();
                n_checked++;
                if (hit !== exp_res.hit) begin
                    $error("hit: expected %0d, got %0d", exp_res.hit, hit);
                    errors++;
                end
                if (index !== exp_res.index) begin
                    $error("buffer_index: expected %h, got %h", exp_res.index, index);
                    errors++;
                end
                if (total !== exp_res.total) begin
                    $error("total_cells: expected %h, got %h", exp_res.total, total);
                    errors++;
                end
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_command;
    logic signed [24:0] i_center_col;
    logic [15:0]        i_band_before;
    logic [15:0]        i_band_after;
    logic [23:0]        i_query_row;
    logic [23:0]        i_query_col;
    logic               i_prior_valid;
    logic [31:0]        i_prior_index;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [23:0]        i_cfg_data;
    logic               o_valid;
    logic               o_hit;
    logic [31:0]        o_buffer_index;
    logic [31:0]        o_total_cells;

    cell_index_scoreboard sb = new();
    int                   cycle_count = 0;
    int                   reg_writes = 0;

    banded_matrix_cell_index_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_center_col   (i_center_col),
        .i_band_before  (i_band_before),
        .i_band_after   (i_band_after),
        .i_query_row    (i_query_row),
        .i_query_col    (i_query_col),
        .i_prior_valid  (i_prior_valid),
        .i_prior_index  (i_prior_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_hit          (o_hit),
        .o_buffer_index (o_buffer_index),
        .o_total_cells  (o_total_cells)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("banded_matrix_cell_index_unit_test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_result(o_hit, o_buffer_index, o_total_cells);
        end
    end

    function automatic logic signed [24:0] rand_center();
        int k;
        k = $urandom_range(0, 99);
        if (k < 10) begin
            return 25'(int'($urandom_range(0, 21)) - 1);
        end
        if (k < 20) begin
            return 25'(COORD_MAX - int'($urandom_range(0, 20)));
        end
        return 25'($urandom_range(0, COORD_MAX));
    endfunction

    function automatic logic [15:0] rand_band();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60) begin
            return 16'($urandom_range(0, 8));
        end
        if (k < 85) begin
            return 16'($urandom_range(0, 300));
        end
        if (k < 95) begin
            return 16'(65535 - $urandom_range(0, 3));
        end
        return 16'($urandom);
    endfunction

    function automatic t_cell_req make_load(logic signed [24:0] ctr, logic [15:0] lc,
                                            logic [15:0] rc);
        t_cell_req req;
        req.command     = CMD_LOAD;
        req.center      = ctr;
        req.left_cells  = lc;
        req.right_cells = rc;
        req.qrow        = 24'($urandom);
        req.qcol        = 24'($urandom);
        req.pvalid      = 1'($urandom);
        req.pindex      = $urandom;
        return req;
    endfunction

    function automatic t_cell_req make_query(logic [23:0] qrow, logic [23:0] qcol,
                                             logic pvalid, logic [31:0] pindex);
        t_cell_req req;
        req.command     = CMD_QUERY;
        req.center      = rand_center();
        req.left_cells  = 16'($urandom);
        req.right_cells = 16'($urandom);
        req.qrow        = qrow;
        req.qcol        = qcol;
        req.pvalid      = pvalid;
        req.pindex      = pindex;
        return req;
    endfunction

    // mostly cells around the band of a loaded row, some prior-index queries, some rows just outside, some noise
    function automatic t_cell_req rand_query();
        int     k;
        longint off;
        longint guide;
        longint lo;
        longint hi;
        longint r;
        longint ctr;
        longint lc;
        longint rc;
        longint col;
        longint qr;
        off   = longint'(sb.row_offset);
        guide = longint'(sb.guide_rows);
        lo    = (off >= 1) ? 0 : 1 - off;
        hi    = guide - 1;
        if (hi > 16777216 - off) begin
            hi = 16777216 - off;
        end
        k = $urandom_range(0, 99);
        if (k < 15) begin
            return make_query(24'($urandom), 24'($urandom), 1'b1,
                              ($urandom_range(0, 3) == 0) ? 32'hFFFFFFFF : $urandom);
        end
        if (k < 80 && lo <= hi) begin
            r   = lo + longint'($urandom_range(0, int'(hi - lo)));
            ctr = longint'(sb.center_tab[r]);
            lc  = longint'(sb.left_tab[r]);
            rc  = longint'(sb.right_tab[r]);
            case ($urandom_range(0, 9))
                0: col = ctr - lc;
                1: col = ctr - lc - 1;
                2: col = ctr + rc;
                3: col = ctr + rc + 1;
                4: col = ctr;
                default: col = ctr - lc - 3 + longint'($urandom_range(0, int'(lc + rc + 6)));
            endcase
            if (col < 0) begin
                col = 0;
            end
            if (col > COORD_MAX) begin
                col = COORD_MAX;
            end
            return make_query(24'(r + off - 1), 24'(col), 1'b0, $urandom);
        end
        if (k < 88) begin
            if ($urandom_range(0, 1) == 1 && off >= 2) begin
                return make_query(24'(off - 2), 24'($urandom), 1'b0, $urandom);
            end
            qr = guide + off - 1;
            if (qr >= 0 && qr <= COORD_MAX) begin
                return make_query(24'(qr), 24'($urandom), 1'b0, $urandom);
            end
        end
        return make_query(24'($urandom), 24'($urandom), 1'b0, $urandom);
    endfunction

    function automatic logic [23:0] pick_offset();
        case ($urandom_range(0, 7))
            0: return 24'd0;
            1: return 24'd1;
            5: return 24'hFFFFFF;
            6: return 24'(COORD_MAX - $urandom_range(0, 30));
            7: return 24'($urandom);
            default: return 24'($urandom_range(0, 40));
        endcase
    endfunction

    function automatic int pick_guide();
        int k;
        k = $urandom_range(0, 99);
        if (k < 10) begin
            return 0;
        end
        if (k < 55) begin
            return sb.rows_loaded;
        end
        return $urandom_range(0, sb.rows_loaded);
    endfunction

    task automatic send(input t_cell_req req, input bit no_idle);
        int gap;
        start         <= 1'b1;
        i_command     <= req.command;
        i_center_col  <= req.center;
        i_band_before <= req.left_cells;
        i_band_after  <= req.right_cells;
        i_query_row   <= req.qrow;
        i_query_col   <= req.qcol;
        i_prior_valid <= req.pvalid;
        i_prior_index <= req.pindex;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(req);
        if (no_idle || $urandom_range(0, 99) < 60) begin
            gap = 0;
        end else if ($urandom_range(0, 99) < 80) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(4, 30);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic quiesce();
        start <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input logic [23:0] offset, input int guide);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ROW_OFFSET;
        i_cfg_data <= offset;
        @(posedge i_clk);
        sb.set_reg(CFG_ROW_OFFSET, offset);
        i_cfg_idx  <= CFG_GUIDE_ROWS;
        i_cfg_data <= 24'(guide);
        @(posedge i_clk);
        sb.set_reg(CFG_GUIDE_ROWS, 24'(guide));
        i_cfg_we   <= 1'b0;
        reg_writes += 2;
    endtask

    initial begin
        t_cell_req req;
        int        sent;
        int        phase_len;
        int        k;
        bit        no_idle;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_command     <= CMD_LOAD;
        i_center_col  <= '0;
        i_band_before <= '0;
        i_band_after  <= '0;
        i_query_row   <= '0;
        i_query_col   <= '0;
        i_prior_valid <= 1'b0;
        i_prior_index <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_ROW_OFFSET;
        i_cfg_data    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);

        // empty guide: every plain query misses, prior index wraps; then the first rows are loaded
        configure(24'd0, 0);
        send(make_query(24'd0, 24'd0, 1'b1, 32'hFFFFFFFF), 1'b0);
        send(make_query(24'hFFFFFF, 24'hFFFFFF, 1'b1, 32'd0), 1'b0);
        send(make_query(24'd0, 24'd0, 1'b0, 32'hFFFFFFFF), 1'b0);
        send(make_query(24'hFFFFFF, 24'hFFFFFF, 1'b0, 32'd0), 1'b0);
        send(make_load(-25'sd1, 16'd0, 16'd0), 1'b0);
        send(make_load(25'sh0FFFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
        send(make_load(25'sd0, 16'hFFFF, 16'd0), 1'b0);
        send(make_load(25'sd100, 16'd3, 16'd5), 1'b0);
        send(make_load(25'sd5000000, 16'd0, 16'hFFFF), 1'b0);

        // band edges on the rows above, query row equals guide row
        quiesce();
        configure(24'd1, 5);
        send(make_query(24'd0, 24'd0, 1'b0, 32'd0), 1'b1);
        send(make_query(24'd1, 24'hFFFFFF, 1'b0, 32'd0), 1'b1);
        send(make_query(24'd1, 24'hFFFFFF - 24'd65535, 1'b0, 32'd0), 1'b1);
        send(make_query(24'd1, 24'hFFFFFF - 24'd65536, 1'b0, 32'd0), 1'b1);
        send(make_query(24'd2, 24'd0, 1'b0, 32'd0), 1'b0);
        send(make_query(24'd3, 24'd97, 1'b0, 32'd0), 1'b0);
        send(make_query(24'd3, 24'd96, 1'b0, 32'd0), 1'b0);
        send(make_query(24'd3, 24'd105, 1'b0, 32'd0), 1'b0);
        send(make_query(24'd3, 24'd106, 1'b0, 32'd0), 1'b0);
        send(make_query(24'd4, 24'd5065535, 1'b0, 32'd0), 1'b0);
        send(make_query(24'd5, 24'd0, 1'b0, 32'd0), 1'b0);
        send(make_query(24'hFFFFFF, 24'd100, 1'b0, 32'd0), 1'b0);
        send(make_query(24'd3, 24'd100, 1'b1, 32'h7FFFFFFF), 1'b0);

        sent = 0;
        while (sent < RAND_ITEMS) begin
            quiesce();
            configure(pick_offset(), pick_guide());
            phase_len = $urandom_range(60, 200);
            no_idle   = ($urandom_range(0, 3) == 0);
            repeat (phase_len) begin
                k = $urandom_range(0, 99);
                if ((sb.rows_loaded < MAX_ROWS && k < 70) || k < 4) begin
                    req = make_load(rand_center(), rand_band(), rand_band());
                end else begin
                    req = rand_query();
                end
                send(req, no_idle);
                sent++;
            end
        end

        // fill the guide, then loads past the end and the full row range
        while (sb.rows_loaded < MAX_ROWS) begin
            send(make_load(rand_center(), rand_band(), rand_band()), 1'b0);
        end
        repeat (3) send(make_load(rand_center(), rand_band(), rand_band()), 1'b0);
        quiesce();
        configure(24'd0, MAX_ROWS);
        repeat (60) send(rand_query(), 1'b0);
        quiesce();
        configure(24'hFFFFFF, MAX_ROWS);
        repeat (20) send(rand_query(), 1'b0);

        quiesce();
        repeat (8) @(posedge i_clk);
        $display("covered %0d requests: %0d guide loads, %0d cell queries, %0d expected hits",
                 sb.n_loads + sb.n_queries, sb.n_loads, sb.n_queries, sb.n_hits);
        $display("%0d guide rows filled, %0d results checked, %0d register writes",
                 sb.rows_loaded, sb.n_checked, reg_writes);
        if (sb.errors == 0) begin
            $display("banded_matrix_cell_index_unit_test passed");
        end else begin
            $display("banded_matrix_cell_index_unit_test failed");
        end
        $finish;
    end

endmodule
